// ===== rtl/cmdu_pkg.sv =====
// Shared types and constants for the message frame TLV deframer.
`timescale 1ns / 1ps

package cmdu_pkg;

  localparam int DEF_MAX_TLVS        = 16;
  localparam int DEF_MAX_VALUE_BYTES = 1024;

  // Header byte that carries the flags; results for the header go out here.
  localparam logic [2:0] HDR_LAST_POS  = 3'd6;
  localparam int         LAST_FRAG_BIT = 7;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_TLV_START = 2'd1,
    KIND_VALUE     = 2'd2,
    KIND_DONE      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_MANY  = 3'd2,
    ST_LONG  = 3'd3,
    ST_TRUNC = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } cmdu_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] cmdu_type;
    logic [15:0] cmdu_mid;
    logic [7:0]  frag_num;
    logic        frag_last;
    logic [7:0]  tlv_type;
    logic [10:0] tlv_length;
    logic [4:0]  tlv_index;
    logic [7:0]  value_byte;
    logic [9:0]  value_offset;
    status_t     status;
    logic        last_result;
  } cmdu_out_t;

  // Up to two results pushed per accepted byte.
  typedef struct packed {
    logic [1:0] count;
    cmdu_out_t  first;
    cmdu_out_t  second;
  } cmdu_push_t;

endpackage

// ===== rtl/cmdu_parse.sv =====
// Frame parser: per-byte state machine producing up to two results.
`timescale 1ns / 1ps

module cmdu_parse import cmdu_pkg::*; #(
  parameter int MAX_TLVS        = DEF_MAX_TLVS,
  parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  cmdu_in_t   in_item,
  input  logic [7:0] eom_type,
  output cmdu_push_t push
);

  localparam int TW = $clog2(MAX_TLVS + 1);
  localparam int VW = $clog2(MAX_VALUE_BYTES + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TLV_HDR,
    PH_VALUE,
    PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic [1:0]  tlv_hdr_cnt, tlv_hdr_cnt_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [15:0] cur_len, cur_len_next;
  logic [VW-1:0] val_cnt, val_cnt_next;
  logic [TW-1:0] tlv_cnt, tlv_cnt_next;
  status_t     err_code, err_code_next;
  logic [15:0] msg_type, msg_type_next;
  logic [15:0] msg_id, msg_id_next;
  logic [7:0]  frag_id, frag_id_next;

  logic [7:0]  b;
  logic [15:0] len_full;
  logic [1:0]  n;
  cmdu_out_t   r0, r1, done_res;
  status_t     st;

  always_comb begin
    b                = in_item.data_byte;
    len_full         = {cur_len[15:8], b};
    phase_next       = phase;
    hdr_pos_next     = hdr_pos;
    tlv_hdr_cnt_next = tlv_hdr_cnt;
    cur_type_next    = cur_type;
    cur_len_next     = cur_len;
    val_cnt_next     = val_cnt;
    tlv_cnt_next     = tlv_cnt;
    err_code_next    = err_code;
    msg_type_next    = msg_type;
    msg_id_next      = msg_id;
    frag_id_next     = frag_id;
    r0               = '0;
    r1               = '0;
    done_res         = '0;
    st               = ST_OK;
    n                = 2'd0;

    unique case (phase)
      PH_HEADER: begin
        case (hdr_pos)
          3'd1:    msg_type_next = {b, 8'h00};
          3'd2:    msg_type_next = {msg_type[15:8], b};
          3'd3:    msg_id_next   = {b, 8'h00};
          3'd4:    msg_id_next   = {msg_id[15:8], b};
          3'd5:    frag_id_next  = b;
          default: ;
        endcase
        if (hdr_pos == HDR_LAST_POS) begin
          r0.kind          = KIND_HEADER;
          r0.cmdu_type     = msg_type;
          r0.cmdu_mid      = msg_id;
          r0.frag_num      = frag_id;
          r0.frag_last     = b[LAST_FRAG_BIT];
          n                = 2'd1;
          phase_next       = PH_TLV_HDR;
          tlv_hdr_cnt_next = 2'd0;
        end else begin
          hdr_pos_next = hdr_pos + 3'd1;
        end
      end
      PH_TLV_HDR: begin
        case (tlv_hdr_cnt)
          2'd0: begin
            cur_type_next    = b;
            tlv_hdr_cnt_next = 2'd1;
          end
          2'd1: begin
            cur_len_next     = {b, 8'h00};
            tlv_hdr_cnt_next = 2'd2;
          end
          default: begin
            cur_len_next     = len_full;
            tlv_hdr_cnt_next = 2'd0;
            if (cur_type == eom_type) begin
              phase_next = PH_SKIP;
            end else if (tlv_cnt >= TW'(MAX_TLVS)) begin
              err_code_next = ST_MANY;
              phase_next    = PH_SKIP;
            end else if (len_full > 16'(MAX_VALUE_BYTES)) begin
              err_code_next = ST_LONG;
              phase_next    = PH_SKIP;
            end else begin
              r0.kind       = KIND_TLV_START;
              r0.tlv_type   = cur_type;
              r0.tlv_length = 11'(len_full);
              r0.tlv_index  = 5'(tlv_cnt);
              n             = 2'd1;
              tlv_cnt_next  = tlv_cnt + TW'(1);
              val_cnt_next  = '0;
              phase_next    = (len_full == 16'd0) ? PH_TLV_HDR : PH_VALUE;
            end
          end
        endcase
      end
      PH_VALUE: begin
        r0.kind         = KIND_VALUE;
        r0.tlv_type     = cur_type;
        r0.tlv_length   = 11'(cur_len);
        r0.tlv_index    = 5'(tlv_cnt - TW'(1));
        r0.value_byte   = b;
        r0.value_offset = 10'(val_cnt);
        n               = 2'd1;
        val_cnt_next    = val_cnt + VW'(1);
        if ((17'(val_cnt) + 17'd1) >= 17'(cur_len)) begin
          phase_next = PH_TLV_HDR;
        end
      end
      PH_SKIP: ;
      default: ;
    endcase

    if (in_item.frame_end) begin
      unique case (phase_next)
        PH_HEADER:  st = ST_SHORT;
        PH_SKIP:    st = err_code_next;
        PH_VALUE:   st = ST_TRUNC;
        PH_TLV_HDR: st = ST_OK;
        default:    st = ST_OK;
      endcase
      done_res.kind        = KIND_DONE;
      done_res.tlv_index   = 5'(tlv_cnt_next);
      done_res.status      = st;
      done_res.last_result = 1'b1;
      if (n == 2'd0) begin
        r0 = done_res;
      end else begin
        r1 = done_res;
      end
      n = n + 2'd1;
      // frame state back to idle
      phase_next       = PH_HEADER;
      hdr_pos_next     = '0;
      tlv_hdr_cnt_next = '0;
      cur_type_next    = '0;
      cur_len_next     = '0;
      val_cnt_next     = '0;
      tlv_cnt_next     = '0;
      err_code_next    = ST_OK;
      msg_type_next    = '0;
      msg_id_next      = '0;
      frag_id_next     = '0;
    end else if (n == 2'd1) begin
      r0.last_result = 1'b1;
    end
  end

  always_comb begin
    push.count  = accept ? n : 2'd0;
    push.first  = r0;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hdr_pos     <= '0;
      tlv_hdr_cnt <= '0;
      cur_type    <= '0;
      cur_len     <= '0;
      val_cnt     <= '0;
      tlv_cnt     <= '0;
      err_code    <= ST_OK;
      msg_type    <= '0;
      msg_id      <= '0;
      frag_id     <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_pos     <= hdr_pos_next;
      tlv_hdr_cnt <= tlv_hdr_cnt_next;
      cur_type    <= cur_type_next;
      cur_len     <= cur_len_next;
      val_cnt     <= val_cnt_next;
      tlv_cnt     <= tlv_cnt_next;
      err_code    <= err_code_next;
      msg_type    <= msg_type_next;
      msg_id      <= msg_id_next;
      frag_id     <= frag_id_next;
    end
  end

endmodule

// ===== rtl/cmdu_resq.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module cmdu_resq import cmdu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmdu_push_t        push,
  output logic              space,
  output logic [QLVL_W-1:0] level,
  output logic              out_valid,
  input  logic              out_ready,
  output cmdu_out_t         out_data
);

  cmdu_out_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head, tail;
  logic              pop;

  assign out_valid = (level != '0);
  assign out_data  = mem[head];
  assign pop       = out_valid && out_ready;
  // room for a worst-case push of two
  assign space     = (level <= QLVL_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[tail + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      tail  <= tail + QPTR_W'(push.count);
      head  <= head + QPTR_W'(pop);
      level <= level + QLVL_W'(push.count) - QLVL_W'(pop);
    end
  end

endmodule

// ===== rtl/cmdu_tlv_deframer.sv =====
// Top level of the message frame TLV deframer.
//
// Usage: frame bytes enter one per request on the in channel (in_valid /
// in_ready, payload in_data with data_byte and frame_end). Byte 0 is the
// version and is dropped; bytes 1..6 form the header, which comes out as one
// header result on byte 6. TLVs follow: a start result per accepted TLV and
// one result per value byte. The byte flagged frame_end also yields a done
// result carrying status and TLV count; last_result marks the final result
// of each byte. After an error status the user drops that frame's results.
// The end-of-message TLV type is set on the cfg channel (cfg_valid /
// cfg_ready / cfg_data); cfg_ready is always high, write only when idle.
// Results: a byte's results are written into the result queue when the byte
// is accepted, and out shows the queue head; a second result queues behind.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_ready is high; a frame-end byte that also gives a header, TLV
// start or value result gives two; the four-entry result queue drains
// them one per cycle while out_ready is high. in_ready drops only when
// the queue cannot take two more, so bytes back up at three pending results.
// Reset: rst (synchronous) returns the parser to the start of a frame,
// empties the queue and clears the end-of-message type to zero.
`timescale 1ns / 1ps

module cmdu_tlv_deframer import cmdu_pkg::*; #(
  parameter int MAX_TLVS        = DEF_MAX_TLVS,
  parameter int MAX_VALUE_BYTES = DEF_MAX_VALUE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmdu_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cmdu_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic              accept;
  logic [7:0]        eom_type;
  cmdu_push_t        push;
  logic [QLVL_W-1:0] level;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // end-of-message TLV type register
  always_ff @(posedge clk) begin
    if (rst) begin
      eom_type <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      eom_type <= cfg_data;
    end
  end

  cmdu_parse #(
    .MAX_TLVS        (MAX_TLVS),
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_data),
    .eom_type (eom_type),
    .push     (push)
  );

  cmdu_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .level     (level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QLVL_W'(QUEUE_DEPTH))
    else $error("result queue level beyond depth");

  // no results without an accepted byte
  a_push_gated: assert property (@(posedge clk) disable iff (rst)
    !accept |-> push.count == 2'd0)
    else $error("results pushed without an accepted byte");

  // a frame-end byte always closes with a done result
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.frame_end |->
      (push.count == 2'd1 && push.first.kind == KIND_DONE) ||
      (push.count == 2'd2 && push.second.kind == KIND_DONE))
    else $error("frame end without done result");

  // done is always the final result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DONE |-> out_data.last_result)
    else $error("done result not marked last");

endmodule
